// ----- sv/rv32im_instruction_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// rv32im instruction decoder assertion macros
// property wrappers shared by the decoder's concurrent checks
// ----------------------------------------------------------------------------
`ifndef RV32IM_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32IM_INSTRUCTION_DECODER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RVID_ASSERT_SAME(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("rvid check failed: same-cycle implication");

// condition holds in the cycle after the trigger
`define RVID_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("rvid check failed: next-cycle implication");

`endif

// ----- sv/rvid_pkg.sv -----
// ----------------------------------------------------------------------------
// rvid_pkg
// opcodes, family and operation codes and the decoded record type
// ----------------------------------------------------------------------------
package rvid_pkg;

	// major opcodes, bits 6:0
	localparam logic [6:0] OPC_REGREG = 7'h33;
	localparam logic [6:0] OPC_REGIMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	// funct7 values
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MEXT = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// system funct12 values
	localparam logic [11:0] F12_ECALL  = 12'h000;
	localparam logic [11:0] F12_EBREAK = 12'h001;
	localparam logic [11:0] F12_MRET   = 12'h302;

	// instruction families
	localparam logic [3:0] FAM_REGREG = 4'd0;
	localparam logic [3:0] FAM_REGIMM = 4'd1;
	localparam logic [3:0] FAM_LOAD   = 4'd2;
	localparam logic [3:0] FAM_STORE  = 4'd3;
	localparam logic [3:0] FAM_BRANCH = 4'd4;
	localparam logic [3:0] FAM_JUMP   = 4'd5;
	localparam logic [3:0] FAM_UPPER  = 4'd6;
	localparam logic [3:0] FAM_SYSTEM = 4'd7;
	localparam logic [3:0] FAM_CSR    = 4'd8;

	// dense operation numbers
	localparam logic [5:0] OP_ADD    = 6'd0;
	localparam logic [5:0] OP_SUB    = 6'd8;
	localparam logic [5:0] OP_SRA    = 6'd9;
	localparam logic [5:0] OP_MUL    = 6'd10;
	localparam logic [5:0] OP_ADDI   = 6'd18;
	localparam logic [5:0] OP_SLTI   = 6'd19;
	localparam logic [5:0] OP_SLTIU  = 6'd20;
	localparam logic [5:0] OP_XORI   = 6'd21;
	localparam logic [5:0] OP_ORI    = 6'd22;
	localparam logic [5:0] OP_ANDI   = 6'd23;
	localparam logic [5:0] OP_SLLI   = 6'd24;
	localparam logic [5:0] OP_SRLI   = 6'd25;
	localparam logic [5:0] OP_SRAI   = 6'd26;
	localparam logic [5:0] OP_LB     = 6'd27;
	localparam logic [5:0] OP_LH     = 6'd28;
	localparam logic [5:0] OP_LW     = 6'd29;
	localparam logic [5:0] OP_LBU    = 6'd30;
	localparam logic [5:0] OP_LHU    = 6'd31;
	localparam logic [5:0] OP_SB     = 6'd32;
	localparam logic [5:0] OP_SH     = 6'd33;
	localparam logic [5:0] OP_SW     = 6'd34;
	localparam logic [5:0] OP_BEQ    = 6'd35;
	localparam logic [5:0] OP_BNE    = 6'd36;
	localparam logic [5:0] OP_BLT    = 6'd37;
	localparam logic [5:0] OP_BGE    = 6'd38;
	localparam logic [5:0] OP_BLTU   = 6'd39;
	localparam logic [5:0] OP_BGEU   = 6'd40;
	localparam logic [5:0] OP_JAL    = 6'd41;
	localparam logic [5:0] OP_JALR   = 6'd42;
	localparam logic [5:0] OP_LUI    = 6'd43;
	localparam logic [5:0] OP_AUIPC  = 6'd44;
	localparam logic [5:0] OP_FENCE  = 6'd45;
	localparam logic [5:0] OP_ECALL  = 6'd46;
	localparam logic [5:0] OP_EBREAK = 6'd47;
	localparam logic [5:0] OP_MRET   = 6'd48;
	localparam logic [5:0] OP_CSRRW  = 6'd49;
	localparam logic [5:0] OP_CSRRS  = 6'd50;
	localparam logic [5:0] OP_CSRRC  = 6'd51;
	localparam logic [5:0] OP_CSRRWI = 6'd52;
	localparam logic [5:0] OP_CSRRSI = 6'd53;
	localparam logic [5:0] OP_CSRRCI = 6'd54;

	// decoded record
	typedef struct packed {
		logic               illegal;
		logic [3:0]         family;
		logic [5:0]         operation;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic [11:0]        csr_address;
		logic [2:0]         func3_field;
		logic [6:0]         func7_field;
		logic [31:0]        raw_word;
	} dec_t;

endpackage

// ----- sv/rv32im_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// rv32im instruction decoder
// two-register decode pipeline for 32-bit RV32IM instruction words
// ----------------------------------------------------------------------------
// each accepted word is held in the input register, decoded by one pass of
// combinational logic and stored in the result register, whose record drives
// the outputs until the output side takes it; one word can be taken every
// cycle while the output side is not stalled.
// the record carries the family, a dense operation number, register indices,
// the format's immediate, the csr address, funct3, funct7 and a copy of the
// word. unknown or malformed encodings raise illegal and zero every field
// except raw_word. no state is kept between words.
`include "rv32im_instruction_decoder_defines.svh"

module rv32im_instruction_decoder
	import rvid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// instruction side
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instr_word,
	// decoded record side
	output logic               out_valid,
	input  logic               out_ready,
	output logic               illegal,
	output logic [3:0]         family,
	output logic [5:0]         operation,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic signed [31:0] immediate,
	output logic [11:0]        csr_address,
	output logic [2:0]         func3_field,
	output logic [6:0]         func7_field,
	output logic [31:0]        raw_word
);

	// pipeline registers
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	dec_t        dec_s2;

	// stage advance: a stage moves when the one after it is empty or moving
	logic        adv_s2;
	logic        adv_s1;

	// decode of the stage 1 word
	dec_t        dec;
	logic        bad;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [11:0] hi12;
	logic [31:0] imm_i;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign opc   = word_s1[6:0];
	assign f3    = word_s1[14:12];
	assign f7    = word_s1[31:25];
	assign hi12  = word_s1[31:20];
	assign imm_i = {{20{word_s1[31]}}, word_s1[31:20]};

	always_comb begin
		dec          = '0;
		dec.raw_word = word_s1;
		bad          = 1'b0;
		unique case (opc)
			OPC_REGREG: begin
				dec.family      = FAM_REGREG;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.src2_reg    = word_s1[24:20];
				dec.func3_field = f3;
				dec.func7_field = f7;
				// m extension then base, alternate funct7 only for sub and sra
				if (f7 == F7_MEXT) begin
					dec.operation = OP_MUL + {3'b000, f3};
				end else if (f7 == F7_BASE) begin
					dec.operation = OP_ADD + {3'b000, f3};
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					dec.operation = OP_SUB;
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					dec.operation = OP_SRA;
				end else begin
					bad = 1'b1;
				end
			end
			OPC_REGIMM: begin
				dec.family      = FAM_REGIMM;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.func3_field = f3;
				dec.func7_field = f7;
				dec.immediate   = $signed(imm_i);
				unique case (f3)
					3'd0: dec.operation = OP_ADDI;
					3'd2: dec.operation = OP_SLTI;
					3'd3: dec.operation = OP_SLTIU;
					3'd4: dec.operation = OP_XORI;
					3'd6: dec.operation = OP_ORI;
					3'd7: dec.operation = OP_ANDI;
					3'd1: begin
						dec.operation = OP_SLLI;
						dec.immediate = $signed({27'd0, word_s1[24:20]});
						bad           = (f7 != F7_BASE);
					end
					default: begin
						// shift right: logical or arithmetic by funct7
						dec.immediate = $signed({27'd0, word_s1[24:20]});
						dec.operation = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
						bad           = (f7 != F7_ALT) && (f7 != F7_BASE);
					end
				endcase
			end
			OPC_LOAD: begin
				dec.family      = FAM_LOAD;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.func3_field = f3;
				dec.immediate   = $signed(imm_i);
				unique case (f3)
					3'd0:    dec.operation = OP_LB;
					3'd1:    dec.operation = OP_LH;
					3'd2:    dec.operation = OP_LW;
					3'd4:    dec.operation = OP_LBU;
					3'd5:    dec.operation = OP_LHU;
					default: bad = 1'b1;
				endcase
			end
			OPC_STORE: begin
				dec.family      = FAM_STORE;
				dec.src1_reg    = word_s1[19:15];
				dec.src2_reg    = word_s1[24:20];
				dec.func3_field = f3;
				dec.immediate   = $signed({{20{word_s1[31]}}, word_s1[31:25],
					word_s1[11:7]});
				unique case (f3)
					3'd0:    dec.operation = OP_SB;
					3'd1:    dec.operation = OP_SH;
					3'd2:    dec.operation = OP_SW;
					default: bad = 1'b1;
				endcase
			end
			OPC_BRANCH: begin
				dec.family      = FAM_BRANCH;
				dec.src1_reg    = word_s1[19:15];
				dec.src2_reg    = word_s1[24:20];
				dec.func3_field = f3;
				dec.immediate   = $signed({{19{word_s1[31]}}, word_s1[31], word_s1[7],
					word_s1[30:25], word_s1[11:8], 1'b0});
				unique case (f3)
					3'd0:    dec.operation = OP_BEQ;
					3'd1:    dec.operation = OP_BNE;
					3'd4:    dec.operation = OP_BLT;
					3'd5:    dec.operation = OP_BGE;
					3'd6:    dec.operation = OP_BLTU;
					3'd7:    dec.operation = OP_BGEU;
					default: bad = 1'b1;
				endcase
			end
			OPC_JAL: begin
				dec.family    = FAM_JUMP;
				dec.operation = OP_JAL;
				dec.dest_reg  = word_s1[11:7];
				dec.immediate = $signed({{11{word_s1[31]}}, word_s1[31], word_s1[19:12],
					word_s1[20], word_s1[30:21], 1'b0});
			end
			OPC_JALR: begin
				dec.family      = FAM_JUMP;
				dec.operation   = OP_JALR;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.func3_field = f3;
				dec.immediate   = $signed(imm_i);
				bad             = (f3 != 3'd0);
			end
			OPC_LUI: begin
				dec.family    = FAM_UPPER;
				dec.operation = OP_LUI;
				dec.dest_reg  = word_s1[11:7];
				dec.immediate = $signed({word_s1[31:12], 12'd0});
			end
			OPC_AUIPC: begin
				dec.family    = FAM_UPPER;
				dec.operation = OP_AUIPC;
				dec.dest_reg  = word_s1[11:7];
				dec.immediate = $signed({word_s1[31:12], 12'd0});
			end
			OPC_FENCE: begin
				dec.family      = FAM_SYSTEM;
				dec.operation   = OP_FENCE;
				dec.dest_reg    = word_s1[11:7];
				dec.src1_reg    = word_s1[19:15];
				dec.func3_field = f3;
				bad             = (f3 != 3'd0);
			end
			OPC_SYSTEM: begin
				unique case (f3)
					3'd0: begin
						// ecall, ebreak, mret: fixed funct12, rd and rs1 zero
						dec.family    = FAM_SYSTEM;
						dec.immediate = $signed({20'd0, hi12});
						unique case (hi12)
							F12_ECALL:  dec.operation = OP_ECALL;
							F12_EBREAK: dec.operation = OP_EBREAK;
							F12_MRET:   dec.operation = OP_MRET;
							default:    bad = 1'b1;
						endcase
						if (word_s1[11:7] != 5'd0 || word_s1[19:15] != 5'd0) begin
							bad = 1'b1;
						end
					end
					3'd4: bad = 1'b1;
					default: begin
						dec.family      = FAM_CSR;
						dec.dest_reg    = word_s1[11:7];
						dec.csr_address = hi12;
						dec.func3_field = f3;
						if (!f3[2]) begin
							dec.operation = OP_CSRRW + {4'd0, f3[1:0]} - 6'd1;
							dec.src1_reg  = word_s1[19:15];
						end else begin
							dec.operation = OP_CSRRWI + {4'd0, f3[1:0]} - 6'd1;
							dec.immediate = $signed({27'd0, word_s1[19:15]});
						end
					end
				endcase
			end
			default: bad = 1'b1;
		endcase

		// illegal encodings keep only the raw word
		if (bad) begin
			dec          = '0;
			dec.illegal  = 1'b1;
			dec.raw_word = word_s1;
		end
	end

	// control: valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, loaded on each transfer into the stage
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= instr_word;
		end
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec;
		end
	end

	assign out_valid   = valid_s2;
	assign illegal     = dec_s2.illegal;
	assign family      = dec_s2.family;
	assign operation   = dec_s2.operation;
	assign dest_reg    = dec_s2.dest_reg;
	assign src1_reg    = dec_s2.src1_reg;
	assign src2_reg    = dec_s2.src2_reg;
	assign immediate   = dec_s2.immediate;
	assign csr_address = dec_s2.csr_address;
	assign func3_field = dec_s2.func3_field;
	assign func7_field = dec_s2.func7_field;
	assign raw_word    = dec_s2.raw_word;

	// an illegal record carries nothing but the raw word
	`RVID_ASSERT_SAME(a_illegal_zero, clk, arst_n, out_valid && illegal,
		family == FAM_REGREG && operation == OP_ADD && dest_reg == 5'd0
		&& src1_reg == 5'd0 && src2_reg == 5'd0 && immediate == 32'sd0
		&& csr_address == 12'd0 && func3_field == 3'd0 && func7_field == 7'd0)

	// an input transfer lands in stage 1 unchanged
	`RVID_ASSERT_NEXT(a_s1_load, clk, arst_n, in_valid && in_ready,
		valid_s1 && word_s1 == $past(instr_word))

	// a stage 1 word moving on shows up as the record's raw word
	`RVID_ASSERT_NEXT(a_s2_load, clk, arst_n, valid_s1 && adv_s2,
		out_valid && raw_word == $past(word_s1))

	// csr records carry the address field of their own word
	`RVID_ASSERT_SAME(a_csr_addr, clk, arst_n, out_valid && !illegal && family == FAM_CSR,
		csr_address == raw_word[31:20] && func3_field != 3'd0 && func3_field != 3'd4)

endmodule

// ----- tb/sv/tb_rv32im_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// rv32im instruction decoder testbench
// directed table then constrained-by-hand random words, with every decoded
// record checked field by field against a typed expectation or an in-bench
// decoder, under random sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module tb_rv32im_instruction_decoder;
	import rvid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// funct3 encodings used to pick operations inside a format
	localparam logic [2:0] F3_ZERO     = 3'd0;
	localparam logic [2:0] F3_SL       = 3'd1;
	localparam logic [2:0] F3_SR       = 3'd5;
	localparam logic [2:0] F3_LW       = 3'd2;
	localparam logic [2:0] F3_LBU      = 3'd4;
	localparam logic [2:0] F3_LHU      = 3'd5;
	localparam logic [2:0] F3_SW       = 3'd2;
	localparam logic [2:0] F3_BNE      = 3'd1;
	localparam logic [2:0] F3_BLT      = 3'd4;
	localparam logic [2:0] F3_CSRRW    = 3'd1;
	localparam logic [2:0] F3_CSRRC    = 3'd3;
	localparam logic [2:0] F3_CSR_RSVD = 3'd4;
	localparam logic [2:0] F3_CSRRWI   = 3'd5;

	localparam int RANDOM_WORDS = 1350;

	// one row of the directed table; want is only used when typed is set
	typedef struct {
		logic [31:0] word;
		bit          typed;
		dec_t        want;
	} stim_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        instr_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               illegal;
	logic [3:0]         family;
	logic [5:0]         operation;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;
	logic [11:0]        csr_address;
	logic [2:0]         func3_field;
	logic [6:0]         func7_field;
	logic [31:0]        raw_word;

	dec_t      expected_recs[$];
	stim_row_t dir_rows[$];
	int        errors = 0;
	int        words_taken = 0;
	int        burst_left = 0;
	bit        cur_typed = 1'b0;
	dec_t      cur_want = '0;

	rv32im_instruction_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.instr_word  (instr_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.illegal     (illegal),
		.family      (family),
		.operation   (operation),
		.dest_reg    (dest_reg),
		.src1_reg    (src1_reg),
		.src2_reg    (src2_reg),
		.immediate   (immediate),
		.csr_address (csr_address),
		.func3_field (func3_field),
		.func7_field (func7_field),
		.raw_word    (raw_word)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decoded record of a single instruction word
	function automatic dec_t decode_word(input logic [31:0] w);
		dec_t        r;
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [11:0] hi12;
		logic [31:0] imm_i;
		bit          bad;
		r     = '0;
		opc   = w[6:0];
		f3    = w[14:12];
		f7    = w[31:25];
		rd    = w[11:7];
		rs1   = w[19:15];
		rs2   = w[24:20];
		hi12  = w[31:20];
		imm_i = {{20{w[31]}}, w[31:20]};
		bad   = 1'b0;
		case (opc)
			OPC_REGREG: begin
				r.family      = FAM_REGREG;
				r.dest_reg    = rd;
				r.src1_reg    = rs1;
				r.src2_reg    = rs2;
				r.func3_field = f3;
				r.func7_field = f7;
				if (f7 == F7_MEXT)
					r.operation = OP_MUL + {3'b000, f3};
				else if (f7 == F7_BASE)
					r.operation = OP_ADD + {3'b000, f3};
				else if (f7 == F7_ALT && f3 == F3_ZERO)
					r.operation = OP_SUB;
				else if (f7 == F7_ALT && f3 == F3_SR)
					r.operation = OP_SRA;
				else
					bad = 1'b1;
			end
			OPC_REGIMM: begin
				r.family      = FAM_REGIMM;
				r.dest_reg    = rd;
				r.src1_reg    = rs1;
				r.func3_field = f3;
				r.func7_field = f7;
				r.immediate   = imm_i;
				case (f3)
					3'd0: r.operation = OP_ADDI;
					3'd1: r.operation = OP_SLLI;
					3'd2: r.operation = OP_SLTI;
					3'd3: r.operation = OP_SLTIU;
					3'd4: r.operation = OP_XORI;
					3'd5: r.operation = OP_SRLI;
					3'd6: r.operation = OP_ORI;
					default: r.operation = OP_ANDI;
				endcase
				// shifts take a zero-extended shamt and a checked funct7
				if (f3 == F3_SL) begin
					r.immediate = {27'b0, rs2};
					if (f7 != F7_BASE)
						bad = 1'b1;
				end else if (f3 == F3_SR) begin
					r.immediate = {27'b0, rs2};
					if (f7 == F7_ALT)
						r.operation = OP_SRAI;
					else if (f7 != F7_BASE)
						bad = 1'b1;
				end
			end
			OPC_LOAD: begin
				r.family      = FAM_LOAD;
				r.dest_reg    = rd;
				r.src1_reg    = rs1;
				r.func3_field = f3;
				r.immediate   = imm_i;
				if (f3 <= F3_LW)
					r.operation = OP_LB + {3'b000, f3};
				else if (f3 == F3_LBU || f3 == F3_LHU)
					r.operation = OP_LBU + {3'b000, f3 - F3_LBU};
				else
					bad = 1'b1;
			end
			OPC_STORE: begin
				r.family      = FAM_STORE;
				r.src1_reg    = rs1;
				r.src2_reg    = rs2;
				r.func3_field = f3;
				r.immediate   = {{20{w[31]}}, w[31:25], w[11:7]};
				if (f3 <= F3_SW)
					r.operation = OP_SB + {3'b000, f3};
				else
					bad = 1'b1;
			end
			OPC_BRANCH: begin
				r.family      = FAM_BRANCH;
				r.src1_reg    = rs1;
				r.src2_reg    = rs2;
				r.func3_field = f3;
				r.immediate   = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				if (f3 <= F3_BNE)
					r.operation = OP_BEQ + {3'b000, f3};
				else if (f3 >= F3_BLT)
					r.operation = OP_BLT + {3'b000, f3 - F3_BLT};
				else
					bad = 1'b1;
			end
			OPC_JAL: begin
				r.family    = FAM_JUMP;
				r.operation = OP_JAL;
				r.dest_reg  = rd;
				r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_JALR: begin
				r.family      = FAM_JUMP;
				r.operation   = OP_JALR;
				r.dest_reg    = rd;
				r.src1_reg    = rs1;
				r.func3_field = f3;
				r.immediate   = imm_i;
				if (f3 != F3_ZERO)
					bad = 1'b1;
			end
			OPC_LUI, OPC_AUIPC: begin
				r.family    = FAM_UPPER;
				r.operation = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
				r.dest_reg  = rd;
				r.immediate = {w[31:12], 12'b0};
			end
			OPC_FENCE: begin
				r.family      = FAM_SYSTEM;
				r.operation   = OP_FENCE;
				r.dest_reg    = rd;
				r.src1_reg    = rs1;
				r.func3_field = f3;
				if (f3 != F3_ZERO)
					bad = 1'b1;
			end
			OPC_SYSTEM: begin
				if (f3 == F3_ZERO) begin
					r.family    = FAM_SYSTEM;
					r.immediate = {20'b0, hi12};
					if (hi12 == F12_ECALL)
						r.operation = OP_ECALL;
					else if (hi12 == F12_EBREAK)
						r.operation = OP_EBREAK;
					else if (hi12 == F12_MRET)
						r.operation = OP_MRET;
					else
						bad = 1'b1;
					if (rd != 5'd0 || rs1 != 5'd0)
						bad = 1'b1;
				end else if (f3 == F3_CSR_RSVD) begin
					bad = 1'b1;
				end else begin
					r.family      = FAM_CSR;
					r.dest_reg    = rd;
					r.csr_address = hi12;
					r.func3_field = f3;
					if (f3 <= F3_CSRRC) begin
						r.operation = OP_CSRRW + {3'b000, f3 - F3_CSRRW};
						r.src1_reg  = rs1;
					end else begin
						r.operation = OP_CSRRWI + {3'b000, f3 - F3_CSRRWI};
						r.immediate = {27'b0, rs1};
					end
				end
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin
			r         = '0;
			r.illegal = 1'b1;
		end
		r.raw_word = w;
		return r;
	endfunction

	// typed expectations for the directed rows
	function automatic dec_t illegal_rec(input logic [31:0] w);
		dec_t r;
		r          = '0;
		r.illegal  = 1'b1;
		r.raw_word = w;
		return r;
	endfunction

	function automatic dec_t system_rec(input logic [5:0] op, input logic [31:0] w);
		dec_t r;
		r           = '0;
		r.family    = FAM_SYSTEM;
		r.operation = op;
		r.immediate = {20'b0, w[31:20]};
		r.raw_word  = w;
		return r;
	endfunction

	// append one row to the directed table
	task automatic add_row(input logic [31:0] w, input bit typed, input dec_t want);
		stim_row_t row;
		row.word  = w;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// random word, mostly well formed with random content, some pure noise
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		logic [6:0]  opcodes[11];
		w = $urandom;
		opcodes = '{OPC_REGREG, OPC_REGIMM, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_JAL,
			OPC_JALR, OPC_LUI, OPC_AUIPC, OPC_FENCE, OPC_SYSTEM};
		if ($urandom_range(0, 99) < 12)
			return w;
		w[6:0] = opcodes[$urandom_range(0, 10)];
		case (w[6:0])
			OPC_REGREG, OPC_REGIMM: begin
				// funct7 mostly one of the meaningful values
				case ($urandom_range(0, 9))
					0, 1, 2: w[31:25] = F7_BASE;
					3, 4, 5: w[31:25] = F7_MEXT;
					6, 7, 8: w[31:25] = F7_ALT;
					default: ;
				endcase
			end
			OPC_JALR, OPC_FENCE: begin
				if ($urandom_range(0, 3) != 0)
					w[14:12] = F3_ZERO;
			end
			OPC_SYSTEM: begin
				// privileged words need exact funct12 and zero rd/rs1
				if ($urandom_range(0, 2) == 0) begin
					w[14:12] = F3_ZERO;
					if ($urandom_range(0, 3) != 0) begin
						case ($urandom_range(0, 2))
							0: w[31:20] = F12_ECALL;
							1: w[31:20] = F12_EBREAK;
							default: w[31:20] = F12_MRET;
						endcase
						if ($urandom_range(0, 4) != 0) begin
							w[11:7]  = 5'd0;
							w[19:15] = 5'd0;
						end
					end
				end
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want,
				got);
			errors++;
		end
	endtask

	// present one word at a falling edge and hold it until the transfer
	task automatic send_word(input logic [31:0] w);
		int gap;
		int target;
		if (burst_left == 0) begin
			// occasional long stretches with no idling at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		instr_word <= w;
		target = words_taken + 1;
		do
			@(negedge clk);
		while (words_taken < target);
	endtask

	// receiver stall pattern, changing mode every so often
	int ready_mode = 0;
	int mode_left = 0;
	int phase_cnt = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(64, 256);
			phase_cnt  = 0;
		end
		mode_left--;
		phase_cnt++;
		case (ready_mode)
			// always ready
			0: out_ready <= 1'b1;
			// random, mostly ready
			1: out_ready <= ($urandom_range(0, 3) != 0);
			// regular single stalls paced by the phase counter
			2: out_ready <= (phase_cnt % 4 != 0);
			// coin-flip readiness, with occasional stalls each followed by a ready window
			default: begin
				if (phase_cnt <= 0)
					out_ready <= 1'b1;
				else if ($urandom_range(0, 7) == 0) begin
					out_ready <= 1'b0;
					phase_cnt = -int'($urandom_range(1, 12));
				end else
					out_ready <= ($urandom_range(0, 1) == 0);
			end
		endcase
	end

	// scoreboard: transfers on both sides are seen at the rising edge
	always @(posedge clk) begin
		dec_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				words_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_recs.size() == 0) begin
					$display("%0t: unexpected record, expected none, actual word %h",
						$realtime, raw_word);
					errors++;
				end else begin
					want = expected_recs.pop_front();
					check_field("illegal", 32'(want.illegal), 32'(illegal));
					check_field("family", 32'(want.family), 32'(family));
					check_field("operation", 32'(want.operation), 32'(operation));
					check_field("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
					check_field("src1_reg", 32'(want.src1_reg), 32'(src1_reg));
					check_field("src2_reg", 32'(want.src2_reg), 32'(src2_reg));
					check_field("immediate", want.immediate, immediate);
					check_field("csr_address", 32'(want.csr_address), 32'(csr_address));
					check_field("func3_field", 32'(want.func3_field), 32'(func3_field));
					check_field("func7_field", 32'(want.func7_field), 32'(func7_field));
					check_field("raw_word", want.raw_word, raw_word);
				end
			end
		end
	end

	// the expectation is queued as the word is handed over, so it is
	// always in place before the record can leave the pipeline
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready && !cur_typed)
			expected_recs.push_back(decode_word(instr_word));
		else if (arst_n && in_valid && in_ready)
			expected_recs.push_back(cur_want);
	end

	initial begin
		// directed table: typed rows for reset-like extremes, privileged words and illegal codes
		add_row(32'h0000_0000, 1'b1, illegal_rec(32'h0000_0000));
		add_row(32'hFFFF_FFFF, 1'b1, illegal_rec(32'hFFFF_FFFF));
		add_row(32'h0000_0073, 1'b1, system_rec(OP_ECALL, 32'h0000_0073));
		add_row(32'h0010_0073, 1'b1, system_rec(OP_EBREAK, 32'h0010_0073));
		add_row(32'h3020_0073, 1'b1, system_rec(OP_MRET, 32'h3020_0073));
		// privileged word with nonzero rd, then with nonzero rs1
		add_row(32'h0000_00F3, 1'b1, illegal_rec(32'h0000_00F3));
		add_row(32'h0010_8073, 1'b1, illegal_rec(32'h0010_8073));
		// unknown funct12
		add_row(32'h0020_0073, 1'b1, illegal_rec(32'h0020_0073));
		// reserved csr funct3
		add_row(32'h0000_4073, 1'b1, illegal_rec(32'h0000_4073));
		// bad funct7 and alt funct7 on the wrong funct3
		add_row(32'h0400_0033, 1'b1, illegal_rec(32'h0400_0033));
		add_row(32'h4000_1033, 1'b1, illegal_rec(32'h4000_1033));
		// shift immediate with a bad funct7
		add_row(32'h4000_1013, 1'b1, illegal_rec(32'h4000_1013));
		add_row(32'h0200_5013, 1'b1, illegal_rec(32'h0200_5013));
		// unused load, store and branch funct3
		add_row(32'h0000_3003, 1'b1, illegal_rec(32'h0000_3003));
		add_row(32'h0000_3023, 1'b1, illegal_rec(32'h0000_3023));
		add_row(32'h0000_2063, 1'b1, illegal_rec(32'h0000_2063));
		// jalr and fence need funct3 zero
		add_row(32'h0000_1067, 1'b1, illegal_rec(32'h0000_1067));
		add_row(32'h0000_100F, 1'b1, illegal_rec(32'h0000_100F));
		// predicted rows: register extremes, immediate extremes, at least one per format
		add_row(32'h01FF_8FB3, 1'b0, '0);
		add_row(32'h4000_5033, 1'b0, '0);
		add_row(32'h0200_7033, 1'b0, '0);
		add_row(32'hFFF0_0013, 1'b0, '0);
		add_row(32'h41F0_5013, 1'b0, '0);
		add_row(32'h8000_2003, 1'b0, '0);
		add_row(32'hFE00_0FA3, 1'b0, '0);
		add_row(32'hFE00_0FE3, 1'b0, '0);
		add_row(32'hFFFF_F0EF, 1'b0, '0);
		add_row(32'hFFFF_F037, 1'b0, '0);
		add_row(32'h0000_1017, 1'b0, '0);
		add_row(32'h0FF0_000F, 1'b0, '0);
		add_row(32'h3000_1073, 1'b0, '0);
		add_row(32'hFFFF_FFF3, 1'b0, '0);

		// single reset at the start
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			cur_typed <= dir_rows[k].typed;
			cur_want  <= dir_rows[k].want;
			send_word(dir_rows[k].word);
		end
		cur_typed <= 1'b0;
		repeat (RANDOM_WORDS)
			send_word(random_word());
		in_valid <= 1'b0;

		// drain, then allow the two-stage pipeline to show any stray record
		while (expected_recs.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// generous limit, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
